// File: sv/rfr_pkg.sv
// Shared types and constants for the rail-fence reorder block.
package rfr_pkg;

    localparam int BYTE_W   = 8;
    localparam int RAILS_W  = 7;
    localparam int PERIOD_W = 8;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } rfr_state_t;

endpackage

// File: sv/rfr_store.sv
// Message byte store: one write port, one registered read port.
module rfr_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [rfr_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [rfr_pkg::BYTE_W-1:0] rd_data
);
    import rfr_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/rail_fence_reorder.sv
// Rail-fence (zigzag) byte reorder: top level with load and emit sequencer.
//
// Usage: a message is loaded one byte per request on in_byte/in_last, taken
// at a clock edge where start is high and busy is low; loading runs at one
// byte per cycle. Bytes beyond MAX_LEN are dropped and the message flagged
// as truncated. The request carrying in_last raises busy and starts emission:
// the stored bytes leave in rail-fence order for num_rails rails on
// out_byte/out_last/truncated, one result per cycle except while the address
// walker changes rail, each marked by valid for a single cycle. The first
// result follows the state register entering emission and then the store's
// read register and valid being loaded. The walker issues no read while it
// changes rail or ends the pass; the final result is shown in the last cycle
// of busy. num_rails is to be written through num_rails_we only while idle:
// the user must keep to this, as the block does not enforce it. Zero acts as
// one rail. The receiver cannot stall: results must be taken as shown. Reset
// clears the byte count and truncation flag and sets num_rails to one.
module rail_fence_reorder #(
    parameter int MAX_LEN = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rfr_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        in_last,
    input  logic                        num_rails_we,
    input  logic [rfr_pkg::RAILS_W-1:0] num_rails,
    output logic                        valid,
    output logic [rfr_pkg::BYTE_W-1:0]  out_byte,
    output logic                        out_last,
    output logic                        truncated
);
    import rfr_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = $clog2(MAX_LEN + 253);

    rfr_state_t           state_reg, state_next;
    logic [RAILS_W-1:0]   rails_reg;
    logic [CW-1:0]        fill_reg, fill_next;
    logic                 ovf_reg, ovf_next;
    logic [RAILS_W-1:0]   rail_reg, rail_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic                 phase_reg, phase_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 valid_reg;
    logic                 last_reg;
    logic                 trunc_reg;

    logic                 accept;
    logic                 room;
    logic                 issue;
    logic [RAILS_W-1:0]   rails_eff;
    logic [PERIOD_W-1:0]  period;
    logic [PERIOD_W-1:0]  two_r;
    logic [PERIOD_W-1:0]  step;
    logic                 end_rail;
    logic [PERIOD_W-1:0]  rail_inc;
    logic                 rails_done;

    assign accept = start && (state_reg == ST_IDLE);
    assign room   = (fill_reg < CW'(MAX_LEN));
    assign busy   = (state_reg != ST_IDLE);

    assign rails_eff = (rails_reg == '0) ? RAILS_W'(1) : rails_reg;
    assign period    = {rails_eff, 1'b0} - PERIOD_W'(2);
    assign two_r     = {rail_reg, 1'b0};
    assign end_rail  = (rail_reg == '0) || (rail_reg == rails_eff - RAILS_W'(1));

    always_comb
    begin
        if (rails_eff == RAILS_W'(1))
        begin
            step = PERIOD_W'(1);
        end
        else if (end_rail)
        begin
            step = period;
        end
        else if (phase_reg)
        begin
            step = two_r;
        end
        else
        begin
            step = period - two_r;
        end
    end

    assign issue      = (state_reg == ST_EMIT) && (pos_reg < PW'(fill_reg));
    assign rail_inc   = PERIOD_W'(rail_reg) + PERIOD_W'(1);
    assign rails_done = (rail_inc >= PERIOD_W'(rails_eff)) ||
                        (rail_inc >= PERIOD_W'(fill_reg));

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        rail_next  = rail_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        state_next = ST_EMIT;
                        rail_next  = '0;
                        pos_next   = '0;
                        phase_next = 1'b0;
                        cnt_next   = '0;
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    pos_next   = pos_reg + PW'(step);
                    phase_next = !phase_reg;
                    cnt_next   = cnt_reg + CW'(1);
                end
                else if (rails_done)
                begin
                    state_next = ST_IDLE;
                    fill_next  = '0;
                    ovf_next   = 1'b0;
                end
                else
                begin
                    rail_next  = rail_inc[RAILS_W-1:0];
                    pos_next   = PW'(rail_inc);
                    phase_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rails_reg <= RAILS_W'(1);
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            rail_reg  <= '0;
            pos_reg   <= '0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            rail_reg  <= rail_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            valid_reg <= issue;
            if (num_rails_we)
            begin
                rails_reg <= num_rails;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            last_reg  <= (cnt_reg == fill_reg - CW'(1));
            trunc_reg <= ovf_reg;
        end
    end

    rfr_store #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && room),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (in_byte),
        .rd_en   (issue),
        .rd_addr (pos_reg[AW-1:0]),
        .rd_data (out_byte)
    );

    assign valid     = valid_reg;
    assign out_last  = valid_reg && last_reg;
    assign truncated = trunc_reg;

endmodule

// File: sv/rfr_checker.sv
// Port-level checks for the rail-fence reorder block, bound to the top level.
module rfr_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic in_last,
    input logic valid,
    input logic out_last
);

    // results only come out of an emission pass
    a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("result outside emission");

    // a last byte starts emission
    a_last_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_last) |=> busy)
        else $error("emission did not start");

    a_out_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_last |-> valid)
        else $error("out_last without result");

    // no result directly follows the final result of a message
    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_last |=> !valid)
        else $error("result after final result");

endmodule

bind rail_fence_reorder rfr_checker u_rfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_last  (in_last),
    .valid    (valid),
    .out_last (out_last)
);
